>>> rtl/core/checksum_and_six_bit_armor_encoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checksum and six-bit armor encoder
// Shared concurrent assertion helpers; they compile to nothing when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef CHECKSUM_AND_SIX_BIT_ARMOR_ENCODER_ASSERT_SVH
`define CHECKSUM_AND_SIX_BIT_ARMOR_ENCODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define CSA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define CSA_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define CSA_ASSERT(lbl, clk, rst, prop)
`define CSA_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> rtl/core/csa_pkg.sv
// ----------------------------------------------------------------------------
// Checksum and six-bit armor encoder package
// Shared types, constants and the character mapping of a three-byte group.
// ----------------------------------------------------------------------------
package csa_pkg;

  // Default depth of the group queue between front and back.
  localparam int QueueDepth = 2;

  // Printable offset added to every six-bit value, and the escaped character.
  localparam logic [6:0] CharBias = 7'h20;
  localparam logic [6:0] Percent  = 7'h25;

  // One complete three-byte group, with the flag for the message's last one.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } group_t;

  // Character number idx (0 to 3) of a group, most significant slice first.
  function automatic logic [6:0] armor_char(group_t g, logic [1:0] idx);
    logic [5:0] sextet;
    case (idx)
      2'd0:    sextet = g.b0[7:2];
      2'd1:    sextet = {g.b0[1:0], g.b1[7:4]};
      2'd2:    sextet = {g.b1[3:0], g.b2[7:6]};
      2'd3:    sextet = g.b2[5:0];
      default: sextet = '0;
    endcase
    return {1'b0, sextet} + CharBias;
  endfunction

endpackage

>>> rtl/core/csa_queue.sv
// ----------------------------------------------------------------------------
// Group queue
// Small register FIFO that carries complete groups from front to back.
// ----------------------------------------------------------------------------
`include "checksum_and_six_bit_armor_encoder_assert.svh"

module csa_queue #(
  parameter int Depth = csa_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  csa_pkg::group_t push_data,
  input  logic            pop,
  output csa_pkg::group_t head,
  output logic            full,
  output logic            empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  csa_pkg::group_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full  = (count == CntW'(Depth));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CSA_NEVER(a_no_push_full, clk, rst, push && full)
  `CSA_NEVER(a_no_pop_empty, clk, rst, pop && empty)
  `CSA_ASSERT(a_count_bound, clk, rst, count <= CntW'(Depth))

endmodule

>>> rtl/core/csa_front.sv
// ----------------------------------------------------------------------------
// Front end: hold window, checksum and grouping
// Delays bytes until they are known to be clear of the checksum slot,
// accumulates the XOR, and packs bytes into three-byte groups. At message end
// it flushes held bytes and zero padding, one per cycle unless queue is full.
// ----------------------------------------------------------------------------
module csa_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  output logic            push,
  output csa_pkg::group_t push_data,
  input  logic            q_full
);

  logic [7:0] win [3];
  logic [1:0] hold_count;
  logic [1:0] bytes_seen;
  logic [7:0] running_xor;
  logic [7:0] group_bytes [2];
  logic [1:0] group_fill;
  logic       flushing;

  logic       take;
  logic       pass;
  logic       flush_go;
  logic       feed;
  logic [7:0] feed_byte;
  logic [7:0] xor_next;
  logic [1:0] seen_next;
  logic [1:0] count_after;
  logic [1:0] fill_after;
  logic       flush_done;

  // A feed that completes a group needs room in the queue.
  assign in_ready = !flushing && !(hold_count == 2'd3 && group_fill == 2'd2 && q_full);
  assign take     = in_valid && in_ready;
  assign pass     = take && (hold_count == 2'd3);
  assign flush_go = flushing && !(group_fill == 2'd2 && q_full);
  assign feed     = pass || flush_go;

  // During a flush, held bytes go first, then zero padding.
  assign feed_byte = (flushing && hold_count == 2'd0) ? 8'h00 : win[0];

  // Checksum covers passed-on bytes from index two onward.
  always_comb begin
    xor_next  = running_xor;
    seen_next = bytes_seen;
    if (pass) begin
      if (bytes_seen == 2'd2) begin
        xor_next = running_xor ^ win[0];
      end else begin
        seen_next = bytes_seen + 1'b1;
      end
    end
  end

  // End-of-flush detection.
  assign count_after = (hold_count != 2'd0) ? hold_count - 1'b1 : 2'd0;
  assign fill_after  = (group_fill == 2'd2) ? 2'd0 : group_fill + 1'b1;
  assign flush_done  = flushing && (count_after == 2'd0) && (fill_after == 2'd0);

  assign push           = feed && (group_fill == 2'd2);
  assign push_data.b0   = group_bytes[0];
  assign push_data.b1   = group_bytes[1];
  assign push_data.b2   = feed_byte;
  assign push_data.last = flush_done;

  // Hold window.
  always_ff @(posedge clk) begin
    if (take) begin
      if (hold_count == 2'd3) begin
        win[0] <= in_end ? xor_next : win[1];
        win[1] <= win[2];
        win[2] <= in_byte;
      end else begin
        win[hold_count] <= in_byte;
        if (in_end && hold_count == 2'd2) begin
          win[0] <= running_xor;
        end
      end
    end else if (flush_go) begin
      win[0] <= win[1];
      win[1] <= win[2];
    end
  end

  // Group collection.
  always_ff @(posedge clk) begin
    if (feed && group_fill != 2'd2) begin
      group_bytes[group_fill[0]] <= feed_byte;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count  <= '0;
      bytes_seen  <= '0;
      running_xor <= '0;
      group_fill  <= '0;
      flushing    <= 1'b0;
    end else begin
      if (feed) begin
        group_fill <= fill_after;
      end
      if (take) begin
        running_xor <= xor_next;
        bytes_seen  <= seen_next;
        if (hold_count != 2'd3) begin
          hold_count <= hold_count + 1'b1;
        end
        if (in_end) begin
          flushing <= 1'b1;
        end
      end else if (flush_go) begin
        hold_count <= count_after;
        if (flush_done) begin
          flushing    <= 1'b0;
          bytes_seen  <= '0;
          running_xor <= '0;
        end
      end
    end
  end

endmodule

>>> rtl/core/csa_back.sv
// ----------------------------------------------------------------------------
// Back end: character emitter
// Turns each queued group into four printable characters, doubling every
// percent sign, and drives the registered output stream.
// ----------------------------------------------------------------------------
module csa_back (
  input  logic            clk,
  input  logic            rst,
  input  csa_pkg::group_t head,
  input  logic            q_empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [6:0]      out_char,
  output logic            out_last
);

  csa_pkg::group_t grp;
  logic            grp_valid;
  logic [1:0]      idx;
  logic            esc;

  logic       out_free;
  logic       step;
  logic [6:0] cur;
  logic       is_pct;
  logic       adv;
  logic       grp_done;

  assign out_free = !out_valid || out_ready;
  assign step     = grp_valid && out_free;
  assign cur      = csa_pkg::armor_char(grp, idx);
  assign is_pct   = (cur == csa_pkg::Percent);
  assign adv      = step && (esc || !is_pct);
  assign grp_done = adv && (idx == 2'd3);
  assign pop      = !q_empty && (!grp_valid || grp_done);

  // Current group and position within it.
  always_ff @(posedge clk) begin
    if (pop) begin
      grp <= head;
    end
  end

  // A newly loaded group restarts at its first character.
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= '0;
      esc       <= 1'b0;
    end else if (pop) begin
      grp_valid <= 1'b1;
      idx       <= '0;
      esc       <= 1'b0;
    end else begin
      if (step) begin
        esc <= !esc && is_pct;
      end
      if (adv) begin
        idx <= idx + 1'b1;
      end
      if (grp_done) begin
        grp_valid <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (step) begin
      out_char <= esc ? csa_pkg::Percent : cur;
      out_last <= grp.last && (idx == 2'd3) && (esc || !is_pct);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> rtl/core/checksum_and_six_bit_armor_encoder.sv
// ----------------------------------------------------------------------------
// Checksum and six-bit armor encoder
// Encodes a byte message into printable characters with an XOR checksum.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle while the front end has queue room; the byte
// third from the end is replaced by the XOR of the bytes from index two up
// to the fourth from last, and the message is zero padded to whole groups
// of three. The back end emits one character per cycle unless the output
// stalls, four per group plus one extra for each doubled percent sign, and
// this character output sets the sustained rate. After the last byte of a
// message the front end flushes the held bytes and pad bytes (up to five),
// during which no new byte is accepted. The final character carries tlast.

module checksum_and_six_bit_armor_encoder #(
  parameter int QUEUE_DEPTH = csa_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_message
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  output logic       m_tlast    // last_char
);

  csa_pkg::group_t push_data;
  csa_pkg::group_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  logic [6:0]      out_char;

  csa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_end    (s_tlast),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  csa_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  csa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (out_char),
    .out_last  (m_tlast)
  );

  assign m_tdata = {1'b0, out_char};

endmodule

>>> tb/sv/checksum_and_six_bit_armor_encoder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Checker for the checksum and six-bit armor encoder
// Watches both stream channels, predicts the armored characters of every
// accepted byte request, and compares each accepted character with the
// oldest prediction.
// ----------------------------------------------------------------------------

module checksum_and_six_bit_armor_encoder_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // end_of_message
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
  input  logic       m_tlast,   // last_char
  output int         mismatches,
  output int         chars_pending
);

  // One predicted character with its end-of-message marker.
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } armored_char_t;

  // Predictor state: bytes held back from the checksum slot, the checksum,
  // and the group of three under assembly.
  logic [7:0]    held [3];
  logic [1:0]    held_count;
  logic [1:0]    forwarded;
  logic [7:0]    checksum;
  logic [7:0]    group_buf [2];
  logic [1:0]    group_count;

  armored_char_t step_chars [$];
  armored_char_t armored_q [$];
  armored_char_t want;
  int            fail_tally = 0;

  function automatic void clear_encoder();
    held[0]      = '0;
    held[1]      = '0;
    held[2]      = '0;
    held_count   = '0;
    forwarded    = '0;
    checksum     = '0;
    group_buf[0] = '0;
    group_buf[1] = '0;
    group_count  = '0;
  endfunction

  // A sextet becomes a printable character; a percent sign is doubled.
  function automatic void emit_sextet(logic [5:0] sextet);
    logic [6:0] ch;
    ch = {1'b0, sextet} + csa_pkg::CharBias;
    step_chars.push_back('{ch: ch, last: 1'b0});
    if (ch == csa_pkg::Percent) step_chars.push_back('{ch: csa_pkg::Percent, last: 1'b0});
  endfunction

  // Collect bytes into groups of three; a full group gives four sextets.
  function automatic void feed_group(logic [7:0] b);
    if (group_count < 2) begin
      group_buf[group_count] = b;
      group_count = group_count + 1'b1;
    end else begin
      emit_sextet(group_buf[0][7:2]);
      emit_sextet({group_buf[0][1:0], group_buf[1][7:4]});
      emit_sextet({group_buf[1][3:0], b[7:6]});
      emit_sextet(b[5:0]);
      group_count = '0;
    end
  endfunction

  // Work out the characters that one accepted byte releases.
  function automatic void predict_armor(logic [7:0] b, logic eom);
    logic [7:0]    oldest;
    armored_char_t tail;
    int            i;
    step_chars.delete();
    if (held_count == 2'd3) begin
      oldest  = held[0];
      held[0] = held[1];
      held[1] = held[2];
      held[2] = b;
      // The first two bytes of a message stay out of the checksum.
      if (forwarded == 2'd2) checksum = checksum ^ oldest;
      else forwarded = forwarded + 1'b1;
      feed_group(oldest);
    end else begin
      held[held_count] = b;
      held_count = held_count + 1'b1;
    end
    if (eom) begin
      // The byte third from the end carries the checksum.
      if (held_count == 2'd3) held[0] = checksum;
      for (i = 0; i < held_count; i++) feed_group(held[i]);
      while (group_count != 0) feed_group(8'h00);
      if (step_chars.size() > 0) begin
        tail = step_chars.pop_back();
        tail.last = 1'b1;
        step_chars.push_back(tail);
      end
      clear_encoder();
    end
    foreach (step_chars[k]) armored_q.push_back(step_chars[k]);
  endfunction

  task automatic note_mismatch(string what, logic [7:0] exp_data, logic exp_last);
    fail_tally++;
    if (fail_tally <= 10)
      $display("mismatch: %s expected data %02h last %0d, got data %02h last %0d",
               what, exp_data, exp_last, m_tdata, m_tlast);
  endtask

  // Byte requests are predicted before characters of the same edge are
  // checked, so a pass-through path would still find its expectation.
  always @(posedge clk) begin
    if (rst) begin
      clear_encoder();
      armored_q.delete();
    end else begin
      if (s_tvalid && s_tready) predict_armor(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (armored_q.size() == 0) begin
          note_mismatch("unexpected character,", 8'h00, 1'b0);
        end else begin
          want = armored_q.pop_front();
          if (m_tdata[6:0] != want.ch || m_tdata[7] != 1'b0 || m_tlast != want.last)
            note_mismatch("character,", {1'b0, want.ch}, want.last);
        end
      end
    end
    mismatches    <= fail_tally;
    chars_pending <= armored_q.size();
  end

endmodule

>>> tb/sv/tb_checksum_and_six_bit_armor_encoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the checksum and six-bit armor encoder
// Sends directed and random byte messages with random gaps and output
// stalls; a separate checker predicts and compares every character.
// ----------------------------------------------------------------------------

module tb_checksum_and_six_bit_armor_encoder;

  localparam int WatchdogLimit = 2000;
  localparam int RandomBytes   = 205;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  int         mismatches;
  int         chars_pending;
  int         stall_cycles = 0;
  bit         quiet = 1'b0;
  logic [7:0] msg_q [$];

  always #4 clk = ~clk;

  checksum_and_six_bit_armor_encoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  checksum_and_six_bit_armor_encoder_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .mismatches    (mismatches),
    .chars_pending (chars_pending)
  );

  // Output side stalls at random, except in quiet stretches.
  always @(posedge clk) begin
    m_tready <= quiet || ($urandom_range(99) >= 32);
  end

  // Watchdog: too many cycles in a row with no request on either channel.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Send the bytes of msg_q as one message, last byte flagged.
  task automatic send_message();
    int k;
    for (k = 0; k < msg_q.size(); k++) begin
      while (!quiet && $urandom_range(99) < 32) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= msg_q[k];
      s_tlast  <= (k == msg_q.size() - 1);
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
  endtask

  // Hold the input back until every predicted character has come out.
  task automatic drain_output();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int sent;
    int msg_idx;
    int len;
    int j;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed messages: one and two bytes (no checksum), three to five
    // bytes (checksum slot becomes zero), percent signs at several slots,
    // a percent on the final character, and all-zero and all-one bytes.
    msg_q = '{8'hFF};
    send_message();
    msg_q = '{8'h00, 8'hFF};
    send_message();
    msg_q = '{8'hA7, 8'h3C, 8'hC5};
    send_message();
    msg_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message();
    msg_q = '{8'h14, 8'h50, 8'h55, 8'h00, 8'h80};
    send_message();
    msg_q = '{8'h01, 8'h02, 8'hFF, 8'h00, 8'h5A, 8'h3F};
    send_message();
    drain_output();

    // Random messages, mostly short, a few long; percent-prone bytes are
    // favored so escapes fall on every character slot.
    sent    = 0;
    msg_idx = 0;
    while (sent < RandomBytes) begin
      quiet = (msg_idx >= 10 && msg_idx < 18);
      if (msg_idx == 24) drain_output();
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(8, 1);
      msg_q.delete();
      for (j = 0; j < len; j++) begin
        case ($urandom_range(7))
          0:       msg_q.push_back({2'($urandom_range(3)), 6'h05});
          1:       msg_q.push_back({6'h05, 2'($urandom_range(3))});
          2:       msg_q.push_back({4'h5, 4'($urandom_range(15))});
          3:       msg_q.push_back(8'h00);
          4:       msg_q.push_back(8'hFF);
          default: msg_q.push_back(8'($urandom));
        endcase
      end
      send_message();
      sent += len;
      msg_idx++;
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    // Wait for the last characters, then a few more cycles for strays.
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
